FILE: rtl/nplt_pkg.sv
// Package: widths, operation and status codes for the nearest point label table.
package nplt_pkg;
	localparam int MaxPointsDef = 64;
	localparam int CoordBitsDef = 17;
	localparam int LabelBits = 16;
	localparam int DistBits = 15;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;
endpackage

FILE: rtl/nplt_if.sv
// Valid/ready channel interfaces for items and results.
interface nplt_in_if #(parameter int CB = 17) ();
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic signed [CB-1:0] pos_x;
	logic signed [CB-1:0] pos_y;
	logic signed [CB-1:0] pos_z;
	logic [15:0] label_tag;
	modport source (output valid, operation, pos_x, pos_y, pos_z, label_tag, input ready);
	modport sink (input valid, operation, pos_x, pos_y, pos_z, label_tag, output ready);
endinterface

interface nplt_out_if #(parameter int CW = 7) ();
	logic valid;
	logic ready;
	logic found;
	logic [1:0] status;
	logic [15:0] nearest_label;
	logic [14:0] nearest_distance;
	logic [CW-1:0] entry_count;
	modport source (output valid, found, status, nearest_label, nearest_distance, entry_count,
		input ready);
	modport sink (input valid, found, status, nearest_label, nearest_distance, entry_count,
		output ready);
endinterface

FILE: rtl/nplt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module nplt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/nplt_isqrt.sv
// Iterative integer square root, two result bits per cycle, of a squared distance.
module nplt_isqrt #(
	parameter int IW = 38,
	localparam int RW = (IW + 1) / 2,
	localparam int STEPS = (RW + 1) / 2,
	localparam int CNTW = $clog2(STEPS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [IW-1:0] radicand,
	output logic          done,
	output logic [RW-1:0] root
);
	localparam int PW = 2 * STEPS * 2;
	logic [PW-1:0] n_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q;

	logic [RW+1:0] rem_a, rem_b;
	logic [RW-1:0] root_a, root_b;
	logic [RW+1:0] trial_a, trial_b;

	// restoring digit recurrence, two digits per cycle
	always_comb begin
		rem_a = {rem_q[RW-1:0], n_q[PW-1 -: 2]};
		trial_a = {root_q, 2'b01};
		if (rem_a >= trial_a) begin
			rem_a = rem_a - trial_a;
			root_a = {root_q[RW-2:0], 1'b1};
		end else
			root_a = {root_q[RW-2:0], 1'b0};
		rem_b = {rem_a[RW-1:0], n_q[PW-3 -: 2]};
		trial_b = {root_a, 2'b01};
		if (rem_b >= trial_b) begin
			rem_b = rem_b - trial_b;
			root_b = {root_a[RW-2:0], 1'b1};
		end else
			root_b = {root_a[RW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= PW'(radicand);
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[PW-5:0], 4'b0};
			rem_q <= rem_b;
			root_q <= root_b;
		end
	end

	assign root = root_q;
endmodule

FILE: rtl/nearest_point_label_table_top.sv
// Top level: point table in RAM, sequencer for add, clear, scan, delete compaction and result.
//
// Usage: one input channel (in) takes an operation with a position and a
// label; one output channel (out) gives one result per item, in order.
// Operations: query nearest, add point, delete nearest, clear table.
// One item is handled at a time; in.ready is high while the sequencer waits.
// Clear, add, and a query or delete on an empty table go straight from the
// idle state to the output state. A query scans every stored entry, newest
// first: for each entry a RAM read, a difference stage, the squares, the sum
// into the square root unit, the root itself (two root bits per step, then a
// done flag) and a compare. A delete then moves the later entries down one
// place, by a read state and a write state for each entry.
// The result waits in an output register; while the receiver stalls, the
// next item is already taken but its result is held back until it is free.
// Reset empties the table at once (the count goes to zero); stored points
// need no clearing since only entries below the count are ever read.
module nearest_point_label_table_top
	import nplt_pkg::*;
#(
	parameter int MAX_POINTS = MaxPointsDef,
	parameter int COORD_BITS = CoordBitsDef,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input logic clk,
	input logic arst_n,
	nplt_in_if.sink in,
	nplt_out_if.source out
);
	localparam int DW = COORD_BITS + 1;
	localparam int SQW = 2 * DW;
	localparam int SUMW = SQW + 2;
	localparam int RW = (SUMW + 1) / 2;
	localparam int PW = 3 * COORD_BITS + LabelBits;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DIFF, S_SQ, S_SUM, S_ROOT, S_CMP, S_MV_RD, S_MV_WR, S_OUT
	} state_t;
	state_t state_q;

	logic [1:0] op_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q, best_q, mv_q;
	logic [DistBits-1:0] best_d_q;
	logic best_v_q;
	logic [LabelBits-1:0] best_lbl_q;

	logic res_found_q;
	logic [1:0] res_status_q;
	logic [LabelBits-1:0] res_label_q;
	logic [DistBits-1:0] res_dist_q;
	logic [CW-1:0] res_count_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [PW-1:0] wdata, rdata;

	nplt_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic signed [COORD_BITS-1:0] rx, ry, rz;
	logic [LabelBits-1:0] rlbl;
	assign {rx, ry, rz, rlbl} = rdata;

	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic [LabelBits-1:0] lbl_s1;
	logic [SQW-1:0] sx_s2, sy_s2, sz_s2;
	logic [SUMW-1:0] sq_sum;
	logic sq_start, sq_done;
	logic [RW-1:0] root;

	// sum feeds the root unit directly so the start edge sees this entry's value
	assign sq_sum = SUMW'(sx_s2) + SUMW'(sy_s2) + SUMW'(sz_s2);

	nplt_isqrt #(.IW(SUMW)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_sum),
		.done(sq_done), .root(root)
	);

	logic [DistBits-1:0] cand_d;
	assign cand_d = DistBits'(root >> 3);

	assign in.ready = (state_q == S_IDLE);
	assign sq_start = (state_q == S_SUM);

	always_comb begin
		raddr = idx_q;
		if (state_q == S_MV_RD)
			raddr = AW'(mv_q + 1'b1);
		we = 1'b0;
		waddr = AW'(count_q);
		wdata = {in.pos_x, in.pos_y, in.pos_z, in.label_tag};
		if (state_q == S_IDLE && in.valid && op_t'(in.operation) == OP_ADD
			&& count_q < CW'(MAX_POINTS))
			we = 1'b1;
		else if (state_q == S_MV_WR) begin
			we = 1'b1;
			waddr = mv_q;
			wdata = rdata;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DW'(rx) - DW'(qx_q);
		dy_s1 <= DW'(ry) - DW'(qy_q);
		dz_s1 <= DW'(rz) - DW'(qz_q);
		lbl_s1 <= rlbl;
		sx_s2 <= SQW'(dx_s1 * dx_s1);
		sy_s2 <= SQW'(dy_s1 * dy_s1);
		sz_s2 <= SQW'(dz_s1 * dz_s1);
	end

	logic [LabelBits-1:0] lbl_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out.valid <= 1'b0;
			op_q <= '0;
		end else begin
			if (out.valid && out.ready && state_q != S_OUT)
				out.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in.valid) begin
					op_q <= in.operation;
					qx_q <= in.pos_x;
					qy_q <= in.pos_y;
					qz_q <= in.pos_z;
					res_found_q <= 1'b0;
					res_status_q <= ST_OK;
					res_label_q <= '0;
					res_dist_q <= '0;
					best_v_q <= 1'b0;
					best_d_q <= '0;
					priority case (op_t'(in.operation))
						OP_CLEAR: begin
							count_q <= '0;
							res_count_q <= '0;
							state_q <= S_OUT;
						end
						OP_ADD: begin
							if (count_q < CW'(MAX_POINTS)) begin
								count_q <= count_q + 1'b1;
								res_count_q <= count_q + 1'b1;
							end else begin
								res_status_q <= ST_FULL;
								res_count_q <= count_q;
							end
							state_q <= S_OUT;
						end
						default: begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								res_count_q <= count_q;
								state_q <= S_OUT;
							end else begin
								idx_q <= AW'(count_q - 1'b1);
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_RD: state_q <= S_DIFF;
				S_DIFF: state_q <= S_SQ;
				S_SQ: begin
					lbl_hold_q <= lbl_s1;
					state_q <= S_SUM;
				end
				S_SUM: state_q <= S_ROOT;
				S_ROOT: if (sq_done) state_q <= S_CMP;
				S_CMP: begin
					if (!best_v_q || cand_d < best_d_q) begin
						best_v_q <= 1'b1;
						best_d_q <= cand_d;
						best_q <= idx_q;
						best_lbl_q <= lbl_hold_q;
					end
					if (idx_q != '0) begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_RD;
					end else begin
						res_found_q <= 1'b1;
						if (!best_v_q || cand_d < best_d_q) begin
							res_label_q <= lbl_hold_q;
							res_dist_q <= cand_d;
						end else begin
							res_label_q <= best_lbl_q;
							res_dist_q <= best_d_q;
						end
						if (op_t'(op_q) == OP_DELETE) begin
							mv_q <= (!best_v_q || cand_d < best_d_q) ? idx_q : best_q;
							state_q <= S_MV_RD;
						end else begin
							res_count_q <= count_q;
							state_q <= S_OUT;
						end
					end
				end
				S_MV_RD: begin
					if (CW'(mv_q) + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						res_count_q <= count_q - 1'b1;
						state_q <= S_OUT;
					end else
						state_q <= S_MV_WR;
				end
				S_MV_WR: begin
					mv_q <= mv_q + 1'b1;
					state_q <= S_MV_RD;
				end
				S_OUT: if (!out.valid || out.ready) begin
					out.valid <= 1'b1;
					out.found <= res_found_q;
					out.status <= res_status_q;
					out.nearest_label <= res_label_q;
					out.nearest_distance <= res_dist_q;
					out.entry_count <= res_count_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS)) else $error("count beyond table size");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in.valid && in.ready) |=> !in.ready) else $error("second item taken while busy");
	a_root_start: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |=> state_q == S_ROOT) else $error("root unit started out of sequence");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.found) |-> out.status == ST_OK) else $error("found with bad status");
endmodule
